// ===== rtl/core/tcf_pkg.sv =====
// shared types, widths and codes of the triangle column-fill rasterizer
package tcf_pkg;

  localparam int CoordBits = 16;
  localparam int ErrBits   = CoordBits + 2;
  localparam int FieldBits = 16;
  localparam int ColorBits = 24;

  // command codes on the input channel
  localparam logic CmdStart = 1'b0;
  localparam logic CmdNext  = 1'b1;

  // result kind codes
  localparam logic KindPixel = 1'b0;
  localparam logic KindEnd   = 1'b1;

  typedef logic [CoordBits-1:0]      coord_t;
  typedef logic signed [ErrBits-1:0] err_t;

  // one bresenham edge walker
  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t end_x;
    coord_t end_y;
    coord_t span_x;
    coord_t span_y;
    err_t   err;
    logic   neg_x;
    logic   neg_y;
  } walk_t;

endpackage

// ===== rtl/core/tcf_if.sv =====
// valid/ready channel interfaces for commands and pixels
interface tcf_in_if;
  logic                             valid;
  logic                             ready;
  logic                             cmd;
  logic [tcf_pkg::FieldBits-1:0]    ax;
  logic [tcf_pkg::FieldBits-1:0]    ay;
  logic [tcf_pkg::FieldBits-1:0]    bx;
  logic [tcf_pkg::FieldBits-1:0]    by;
  logic [tcf_pkg::FieldBits-1:0]    cx;
  logic [tcf_pkg::FieldBits-1:0]    cy;

  modport source (output valid, cmd, ax, ay, bx, by, cx, cy, input ready);
  modport sink (input valid, cmd, ax, ay, bx, by, cx, cy, output ready);
endinterface

interface tcf_out_if;
  logic                             valid;
  logic                             ready;
  logic                             kind;
  logic [tcf_pkg::FieldBits-1:0]    px;
  logic [tcf_pkg::FieldBits-1:0]    py;
  logic [tcf_pkg::ColorBits-1:0]    pcolor;

  modport source (output valid, kind, px, py, pcolor, input ready);
  modport sink (input valid, kind, px, py, pcolor, output ready);
endinterface

// ===== rtl/core/tcf_init.sv =====
// edge walker setup from a start and an end point
module tcf_init (
  input  tcf_pkg::coord_t x0,
  input  tcf_pkg::coord_t y0,
  input  tcf_pkg::coord_t x1,
  input  tcf_pkg::coord_t y1,
  output tcf_pkg::walk_t  w
);

  always_comb begin
    w.x      = x0;
    w.y      = y0;
    w.end_x  = x1;
    w.end_y  = y1;
    w.neg_x  = x0 > x1;
    w.neg_y  = y0 > y1;
    w.span_x = (x0 > x1) ? x0 - x1 : x1 - x0;
    w.span_y = (y0 > y1) ? y0 - y1 : y1 - y0;
    if (w.span_x > w.span_y) begin
      w.err = $signed({2'b00, w.span_x >> 1});
    end else begin
      w.err = -$signed({2'b00, w.span_y >> 1});
    end
  end

endmodule

// ===== rtl/core/tcf_step.sv =====
// shared bresenham step unit, one walker step per use
module tcf_step (
  input  tcf_pkg::walk_t cur,
  output tcf_pkg::walk_t nxt,
  output logic           moved
);

  logic          at_end;
  logic          step_x;
  logic          step_y;
  tcf_pkg::err_t sx_e;
  tcf_pkg::err_t sy_e;
  tcf_pkg::err_t err_a;

  always_comb begin
    sx_e   = $signed({2'b00, cur.span_x});
    sy_e   = $signed({2'b00, cur.span_y});
    at_end = (cur.x == cur.end_x) && (cur.y == cur.end_y);
    step_x = cur.err > -sx_e;
    step_y = cur.err < sy_e;
    err_a  = step_x ? cur.err - sy_e : cur.err;
    nxt    = cur;
    moved  = !at_end;
    if (!at_end) begin
      if (step_x) begin
        nxt.x = cur.neg_x ? cur.x - 1'b1 : cur.x + 1'b1;
      end
      if (step_y) begin
        nxt.y = cur.neg_y ? cur.y - 1'b1 : cur.y + 1'b1;
      end
      nxt.err = step_y ? err_a + sx_e : err_a;
    end
  end

endmodule

// ===== rtl/core/triangle_column_fill_rasterizer.sv =====
// top level: triangle column-fill rasterizer with shared edge step unit
//
//   channel   dir  beat payload                  role
//   cmd_ch    in   cmd, ax, ay, bx, by, cx, cy   start a triangle or ask for next pixel
//   pix_ch    out  kind, px, py, pcolor          one pixel or the end marker
//   cfg       in   cfg_we, cfg_data              draw_color register write
//
// a start beat runs 3 compare-swap steps to sort the vertices by x, then 3 setup steps,
// one per walker, before the input is ready again
// a next beat passes the run and put states for a stored pixel or the end marker; each
// walker step and each short edge that runs out adds a run state, and each new column
// adds the long-edge advance and the fill setup states
// reset is synchronous, clears the sequencer, phase, output valid and draw_color
// a pending pixel sits in the output register; the next beat is taken meanwhile
// and only its own result waits for the output register to drain
module triangle_column_fill_rasterizer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [tcf_pkg::ColorBits-1:0] cfg_data,
  tcf_in_if.sink                        cmd_ch,
  tcf_out_if.source                     pix_ch
);

  // sequencer codes
  localparam logic [2:0] SqWait = 3'd0;
  localparam logic [2:0] SqSort = 3'd1;
  localparam logic [2:0] SqInit = 3'd2;
  localparam logic [2:0] SqRun  = 3'd3;
  localparam logic [2:0] SqLong = 3'd4;
  localparam logic [2:0] SqFset = 3'd5;
  localparam logic [2:0] SqPut  = 3'd6;

  // triangle phase codes
  localparam logic [2:0] PhIdle   = 3'd0;
  localparam logic [2:0] PhFirst  = 3'd1;
  localparam logic [2:0] PhWalkAb = 3'd2;
  localparam logic [2:0] PhWalkBc = 3'd3;
  localparam logic [2:0] PhFillAb = 3'd4;
  localparam logic [2:0] PhFillBc = 3'd5;
  localparam logic [2:0] PhDone   = 3'd6;

  // walker select codes
  localparam logic [1:0] WSelAb   = 2'd0;
  localparam logic [1:0] WSelBc   = 2'd1;
  localparam logic [1:0] WSelLong = 2'd2;

  localparam logic [1:0] LastStep = 2'd2;

  logic [2:0]                    sq;
  logic [1:0]                    cnt;
  logic [2:0]                    phase;
  logic [tcf_pkg::ColorBits-1:0] draw_color;

  // vertex registers, sorted in place
  tcf_pkg::coord_t vx0, vy0, vx1, vy1, vx2, vy2;

  // edge walkers: a-b, b-c and the long edge a-c
  tcf_pkg::walk_t w0, w1, w2;

  tcf_pkg::coord_t last_column;
  tcf_pkg::coord_t fill_x;
  tcf_pkg::coord_t fill_y;
  tcf_pkg::coord_t fill_y_end;

  // result waiting for the output register
  logic                          res_kind;
  logic [tcf_pkg::FieldBits-1:0] res_x;
  logic [tcf_pkg::FieldBits-1:0] res_y;
  logic [tcf_pkg::ColorBits-1:0] res_color;

  // output register
  logic                          out_valid;
  logic                          out_kind;
  logic [tcf_pkg::FieldBits-1:0] out_px;
  logic [tcf_pkg::FieldBits-1:0] out_py;
  logic [tcf_pkg::ColorBits-1:0] out_color;
  // output register loads from the put state
  logic                          put_fire;

  // compare-swap and setup operands
  tcf_pkg::coord_t sa_x, sb_x;
  logic            swap;
  tcf_pkg::coord_t ia_x, ia_y, ib_x, ib_y;
  tcf_pkg::walk_t  init_w;

  // step unit operands
  logic [1:0]      wsel;
  tcf_pkg::walk_t  cur;
  tcf_pkg::walk_t  nxt;
  logic            moved;
  tcf_pkg::coord_t y_lo, y_hi;
  logic            fill_done;

  assign cmd_ch.ready  = (sq == SqWait);
  assign pix_ch.valid  = out_valid;
  assign pix_ch.kind   = out_kind;
  assign pix_ch.px     = out_px;
  assign pix_ch.py     = out_py;
  assign pix_ch.pcolor = out_color;

  assign put_fire = (sq == SqPut) && (!out_valid || pix_ch.ready);

  // sort network: (a,c), (b,c), (a,b), swap on strict less-than
  always_comb begin
    case (cnt)
      2'd0: begin
        sa_x = vx0;
        sb_x = vx2;
      end
      2'd1: begin
        sa_x = vx1;
        sb_x = vx2;
      end
      default: begin
        sa_x = vx0;
        sb_x = vx1;
      end
    endcase
    swap = sb_x < sa_x;
  end

  // walker setup end points
  always_comb begin
    case (cnt)
      2'd0: begin
        ia_x = vx0;
        ia_y = vy0;
        ib_x = vx1;
        ib_y = vy1;
      end
      2'd1: begin
        ia_x = vx1;
        ia_y = vy1;
        ib_x = vx2;
        ib_y = vy2;
      end
      default: begin
        ia_x = vx0;
        ia_y = vy0;
        ib_x = vx2;
        ib_y = vy2;
      end
    endcase
  end

  tcf_init u_init (
    .x0 (ia_x),
    .y0 (ia_y),
    .x1 (ib_x),
    .y1 (ib_y),
    .w  (init_w)
  );

  // pick the walker that the step unit works on
  always_comb begin
    if (sq == SqLong) begin
      wsel = WSelLong;
    end else if (phase == PhWalkBc) begin
      wsel = WSelBc;
    end else begin
      wsel = WSelAb;
    end
    case (wsel)
      WSelAb:  cur = w0;
      WSelBc:  cur = w1;
      default: cur = w2;
    endcase
  end

  tcf_step u_step (
    .cur   (cur),
    .nxt   (nxt),
    .moved (moved)
  );

  // column span between the short edge and the long edge
  always_comb begin
    y_lo      = (cur.y < w2.y) ? cur.y : w2.y;
    y_hi      = (cur.y < w2.y) ? w2.y : cur.y;
    fill_done = fill_y >= fill_y_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq         <= SqWait;
      cnt        <= '0;
      phase      <= PhIdle;
      out_valid  <= 1'b0;
      draw_color <= '0;
    end else begin
      if (cfg_we) begin
        draw_color <= cfg_data;
      end
      if (put_fire) begin
        out_valid <= 1'b1;
      end else if (out_valid && pix_ch.ready) begin
        out_valid <= 1'b0;
      end
      case (sq)
        SqWait: begin
          if (cmd_ch.valid) begin
            if (cmd_ch.cmd == tcf_pkg::CmdStart) begin
              vx0         <= cmd_ch.ax[tcf_pkg::CoordBits-1:0];
              vy0         <= cmd_ch.ay[tcf_pkg::CoordBits-1:0];
              vx1         <= cmd_ch.bx[tcf_pkg::CoordBits-1:0];
              vy1         <= cmd_ch.by[tcf_pkg::CoordBits-1:0];
              vx2         <= cmd_ch.cx[tcf_pkg::CoordBits-1:0];
              vy2         <= cmd_ch.cy[tcf_pkg::CoordBits-1:0];
              last_column <= '0;
              fill_x      <= '0;
              fill_y      <= '0;
              fill_y_end  <= '0;
              phase       <= PhFirst;
              cnt         <= '0;
              sq          <= SqSort;
            end else begin
              sq <= SqRun;
            end
          end
        end
        SqSort: begin
          if (swap) begin
            case (cnt)
              2'd0: begin
                vx0 <= vx2;
                vx2 <= vx0;
                vy0 <= vy2;
                vy2 <= vy0;
              end
              2'd1: begin
                vx1 <= vx2;
                vx2 <= vx1;
                vy1 <= vy2;
                vy2 <= vy1;
              end
              default: begin
                vx0 <= vx1;
                vx1 <= vx0;
                vy0 <= vy1;
                vy1 <= vy0;
              end
            endcase
          end
          if (cnt == LastStep) begin
            cnt <= '0;
            sq  <= SqInit;
          end else begin
            cnt <= cnt + 2'd1;
          end
        end
        SqInit: begin
          case (cnt)
            2'd0:    w0 <= init_w;
            2'd1:    w1 <= init_w;
            default: w2 <= init_w;
          endcase
          if (cnt == LastStep) begin
            cnt <= '0;
            sq  <= SqWait;
          end else begin
            cnt <= cnt + 2'd1;
          end
        end
        SqRun: begin
          case (phase)
            PhFirst: begin
              // leftmost vertex, start of the long edge
              last_column <= w2.x;
              phase       <= PhWalkAb;
              res_kind    <= tcf_pkg::KindPixel;
              res_x       <= tcf_pkg::FieldBits'(w2.x);
              res_y       <= tcf_pkg::FieldBits'(w2.y);
              res_color   <= draw_color;
              sq          <= SqPut;
            end
            PhFillAb, PhFillBc: begin
              res_kind  <= tcf_pkg::KindPixel;
              res_x     <= tcf_pkg::FieldBits'(fill_x);
              res_y     <= tcf_pkg::FieldBits'(fill_y);
              res_color <= draw_color;
              if (fill_done) begin
                phase <= (phase == PhFillAb) ? PhWalkAb : PhWalkBc;
              end else begin
                fill_y <= fill_y + 1'b1;
              end
              sq <= SqPut;
            end
            PhWalkAb, PhWalkBc: begin
              if (!moved) begin
                // short edge exhausted, move on to the next one or finish
                phase <= (phase == PhWalkAb) ? PhWalkBc : PhDone;
              end else begin
                case (wsel)
                  WSelAb:  w0 <= nxt;
                  WSelBc:  w1 <= nxt;
                  default: w2 <= nxt;
                endcase
                if (nxt.x != last_column) begin
                  sq <= SqLong;
                end
              end
            end
            default: begin
              // idle, done or an unused phase code: end marker
              res_kind  <= tcf_pkg::KindEnd;
              res_x     <= '0;
              res_y     <= '0;
              res_color <= '0;
              sq        <= SqPut;
            end
          endcase
        end
        SqLong: begin
          // advance the long edge until it leaves the previous column or reaches its end point
          if ((w2.x == last_column) && moved) begin
            w2 <= nxt;
          end else begin
            sq <= SqFset;
          end
        end
        SqFset: begin
          fill_x      <= cur.x;
          last_column <= cur.x;
          fill_y      <= y_lo;
          fill_y_end  <= y_hi;
          phase       <= (phase == PhWalkAb) ? PhFillAb : PhFillBc;
          sq          <= SqRun;
        end
        SqPut: begin
          if (put_fire) begin
            out_kind  <= res_kind;
            out_px    <= res_x;
            out_py    <= res_y;
            out_color <= res_color;
            sq        <= SqWait;
          end
        end
        default: begin
          sq <= SqWait;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/tcf_checker.sv =====
// port-level checks for the triangle column-fill rasterizer and their bind
module tcf_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_kind,
  input logic [tcf_pkg::FieldBits-1:0] out_px,
  input logic [tcf_pkg::FieldBits-1:0] out_py,
  input logic [tcf_pkg::ColorBits-1:0] out_pcolor
);

  // a stalled pixel beat stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("pixel beat dropped while stalled");

  // end marker carries an all-zero payload
  a_end_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_kind == tcf_pkg::KindEnd)) |->
      ((out_px == '0) && (out_py == '0) && (out_pcolor == '0)))
    else $error("end marker with nonzero payload");

  // one beat at a time: input closes right after an accept
  a_one_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input still open after accepted beat");

  // a new result only appears after the block was busy
  a_res_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared while input was open");

endmodule

bind triangle_column_fill_rasterizer tcf_checker u_tcf_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (cmd_ch.valid),
  .in_ready   (cmd_ch.ready),
  .out_valid  (pix_ch.valid),
  .out_ready  (pix_ch.ready),
  .out_kind   (pix_ch.kind),
  .out_px     (pix_ch.px),
  .out_py     (pix_ch.py),
  .out_pcolor (pix_ch.pcolor)
);

// ===== verif/tcf_result_checker.sv =====
// result checker: predicts the rasterizer's pixel beats and compares them in order
module tcf_result_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [tcf_pkg::ColorBits-1:0] cfg_data,
  tcf_in_if                             cmd_ch,
  tcf_out_if                            pix_ch,
  output int                            mismatches,
  output int                            pending,
  output int                            pixels_seen,
  output int                            ends_seen
);
  import tcf_pkg::*;

  typedef logic [ColorBits-1:0] color_t;

  typedef enum logic [2:0] {
    RAST_IDLE,
    RAST_FIRST,
    RAST_WALK_AB,
    RAST_WALK_BC,
    RAST_FILL_AB,
    RAST_FILL_BC,
    RAST_DONE
  } rast_phase_t;

  // one edge walker; error kept as a plain int
  typedef struct {
    coord_t x;
    coord_t y;
    coord_t end_x;
    coord_t end_y;
    coord_t span_x;
    coord_t span_y;
    int     err;
    logic   neg_x;
    logic   neg_y;
  } edge_t;

  typedef struct packed {
    logic   kind;
    coord_t px;
    coord_t py;
    color_t pcolor;
  } pixel_t;

  // edges: 0 = a-b, 1 = b-c, 2 = a-c
  edge_t       edges [3];
  rast_phase_t phase_q;
  coord_t      last_col;
  coord_t      fill_x;
  coord_t      fill_y;
  coord_t      fill_y_end;
  color_t      draw_color_q;
  pixel_t      expected_pixels [$];

  function automatic pixel_t make_pixel(logic kind, coord_t x, coord_t y, color_t c);
    pixel_t p;
    p.kind   = kind;
    p.px     = x;
    p.py     = y;
    p.pcolor = c;
    return p;
  endfunction

  function automatic void rast_reset();
    for (int k = 0; k < 3; k++) begin
      edges[k] = '{default: 0};
    end
    phase_q    = RAST_IDLE;
    last_col   = '0;
    fill_x     = '0;
    fill_y     = '0;
    fill_y_end = '0;
  endfunction

  function automatic void edge_setup(int k, coord_t x0, coord_t y0, coord_t x1, coord_t y1);
    int half;
    edges[k].x      = x0;
    edges[k].y      = y0;
    edges[k].end_x  = x1;
    edges[k].end_y  = y1;
    edges[k].neg_x  = x0 > x1;
    edges[k].neg_y  = y0 > y1;
    edges[k].span_x = (x0 > x1) ? x0 - x1 : x1 - x0;
    edges[k].span_y = (y0 > y1) ? y0 - y1 : y1 - y0;
    if (edges[k].span_x > edges[k].span_y) begin
      half = edges[k].span_x >> 1;
      edges[k].err = half;
    end else begin
      half = edges[k].span_y >> 1;
      edges[k].err = -half;
    end
  endfunction

  // one bresenham step; false when already at the end point
  function automatic bit edge_step(int k);
    int e;
    int sx;
    int sy;
    e  = edges[k].err;
    sx = edges[k].span_x;
    sy = edges[k].span_y;
    if (edges[k].x == edges[k].end_x && edges[k].y == edges[k].end_y) begin
      return 1'b0;
    end
    if (e > -sx) begin
      edges[k].err = edges[k].err - sy;
      edges[k].x   = edges[k].neg_x ? edges[k].x - 1'b1 : edges[k].x + 1'b1;
    end
    if (e < sy) begin
      edges[k].err = edges[k].err + sx;
      edges[k].y   = edges[k].neg_y ? edges[k].y - 1'b1 : edges[k].y + 1'b1;
    end
    return 1'b1;
  endfunction

  function automatic void triangle_load(coord_t vax, coord_t vay, coord_t vbx, coord_t vby,
                                        coord_t vcx, coord_t vcy);
    coord_t x0, y0, x1, y1, x2, y2, t;
    x0 = vax;
    y0 = vay;
    x1 = vbx;
    y1 = vby;
    x2 = vcx;
    y2 = vcy;
    // three compare-swaps on strict less-than
    if (x2 < x0) begin
      t = x2; x2 = x0; x0 = t;
      t = y2; y2 = y0; y0 = t;
    end
    if (x2 < x1) begin
      t = x2; x2 = x1; x1 = t;
      t = y2; y2 = y1; y1 = t;
    end
    if (x1 < x0) begin
      t = x1; x1 = x0; x0 = t;
      t = y1; y1 = y0; y0 = t;
    end
    edge_setup(0, x0, y0, x1, y1);
    edge_setup(1, x1, y1, x2, y2);
    edge_setup(2, x0, y0, x2, y2);
    last_col   = '0;
    fill_x     = '0;
    fill_y     = '0;
    fill_y_end = '0;
    phase_q    = RAST_FIRST;
  endfunction

  // emits the current fill pixel, returns to the walk when the column is done
  function automatic pixel_t column_emit(rast_phase_t resume);
    coord_t y;
    y = fill_y;
    if (fill_y >= fill_y_end) begin
      phase_q = resume;
    end else begin
      fill_y = fill_y + 1'b1;
    end
    return make_pixel(KindPixel, fill_x, y, draw_color_q);
  endfunction

  function automatic pixel_t predict_next();
    pixel_t r;
    bit     have;
    bit     moving;
    int     k;
    coord_t ey;
    coord_t ly;
    r    = '0;
    have = 1'b0;
    while (!have) begin
      case (phase_q)
        RAST_FIRST: begin
          last_col = edges[2].x;
          phase_q  = RAST_WALK_AB;
          r        = make_pixel(KindPixel, edges[2].x, edges[2].y, draw_color_q);
          have     = 1'b1;
        end
        RAST_FILL_AB: begin
          r    = column_emit(RAST_WALK_AB);
          have = 1'b1;
        end
        RAST_FILL_BC: begin
          r    = column_emit(RAST_WALK_BC);
          have = 1'b1;
        end
        RAST_WALK_AB, RAST_WALK_BC: begin
          k = (phase_q == RAST_WALK_AB) ? 0 : 1;
          if (!edge_step(k)) begin
            phase_q = (k == 0) ? RAST_WALK_BC : RAST_DONE;
          end else if (edges[k].x != last_col) begin
            // bring the long edge out of the previous column
            moving = 1'b1;
            while (moving && edges[2].x == last_col) begin
              moving = edge_step(2);
            end
            ey         = edges[k].y;
            ly         = edges[2].y;
            fill_x     = edges[k].x;
            fill_y     = (ey < ly) ? ey : ly;
            fill_y_end = (ey < ly) ? ly : ey;
            last_col   = edges[k].x;
            phase_q    = (k == 0) ? RAST_FILL_AB : RAST_FILL_BC;
            r          = column_emit((k == 0) ? RAST_WALK_AB : RAST_WALK_BC);
            have       = 1'b1;
          end
        end
        default: begin
          r    = make_pixel(KindEnd, '0, '0, '0);
          have = 1'b1;
        end
      endcase
    end
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    pixel_t got;
    pixel_t want;
    if (rst) begin
      rast_reset();
      draw_color_q = '0;
      expected_pixels.delete();
      mismatches  = 0;
      pixels_seen = 0;
      ends_seen   = 0;
    end else begin
      // output beat first: its expectation was queued at an earlier edge
      if (pix_ch.valid && pix_ch.ready) begin
        got = make_pixel(pix_ch.kind, pix_ch.px, pix_ch.py, pix_ch.pcolor);
        if (got.kind == KindEnd) begin
          ends_seen++;
        end else begin
          pixels_seen++;
        end
        if (expected_pixels.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("pixel beat %0d with nothing expected: kind %0d (%0d,%0d) color %06h",
                     pixels_seen + ends_seen, got.kind, got.px, got.py, got.pcolor);
          end
        end else begin
          want = expected_pixels.pop_front();
          if (got.kind !== want.kind || got.px !== want.px || got.py !== want.py ||
              got.pcolor !== want.pcolor) begin
            mismatches++;
            if (mismatches <= 10) begin
              $write("pixel beat %0d: want kind %0d (%0d,%0d) color %06h, ",
                     pixels_seen + ends_seen, want.kind, want.px, want.py, want.pcolor);
              $display("got kind %0d (%0d,%0d) color %06h",
                       got.kind, got.px, got.py, got.pcolor);
            end
          end
        end
      end
      if (cmd_ch.valid && cmd_ch.ready) begin
        if (cmd_ch.cmd == CmdStart) begin
          triangle_load(cmd_ch.ax, cmd_ch.ay, cmd_ch.bx, cmd_ch.by, cmd_ch.cx, cmd_ch.cy);
        end else begin
          expected_pixels.push_back(predict_next());
        end
      end
      if (cfg_we) begin
        draw_color_q = cfg_data;
      end
    end
    pending = expected_pixels.size();
  end

endmodule

// ===== verif/triangle_column_fill_rasterizer_test.sv =====
// testbench top: stimulus, idling and verdict for the triangle column-fill rasterizer
module triangle_column_fill_rasterizer_test;
  import tcf_pkg::*;

  typedef logic [FieldBits-1:0] field_t;

  // a single next beat may walk three full-length edges, one step per cycle
  localparam int StallLimit  = 2_000_000;
  localparam int RandomBeats = 1750;
  // a color write once at least this many command beats have gone by
  localparam int ColorEvery  = 150;
  // start setup runs the sort and the walker setup; give it a margin before touching the register
  localparam int SettlePause = 16;
  localparam int DrainPause  = 40;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [ColorBits-1:0] cfg_data;

  tcf_in_if  cmd_ch ();
  tcf_out_if pix_ch ();

  int mismatches;
  int pending;
  int pixels_seen;
  int ends_seen;
  int send_idle;
  int recv_idle;
  int beats_sent;
  int color_writes;
  int stall_cycles;

  triangle_column_fill_rasterizer dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .cmd_ch   (cmd_ch),
    .pix_ch   (pix_ch)
  );

  tcf_result_checker chk (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .cmd_ch      (cmd_ch),
    .pix_ch      (pix_ch),
    .mismatches  (mismatches),
    .pending     (pending),
    .pixels_seen (pixels_seen),
    .ends_seen   (ends_seen)
  );

  // 8 unit clock period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver back-pressure, changed on the falling edge
  always @(negedge clk) begin
    pix_ch.ready <= (recv_idle == 0) || ($urandom_range(99) >= recv_idle);
  end

  // watchdog: cycles with no beat on either channel
  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (pix_ch.valid && pix_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("watchdog: no beat for %0d cycles, %0d results outstanding",
               stall_cycles, pending);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic field_t rand_field();
    return field_t'($urandom_range(0, 16'hFFFF));
  endfunction

  // offers one command beat, with random sender gaps in front; enters and
  // leaves on a falling edge, valid stays high for a following beat
  task automatic drive_beat(input logic c, input field_t vax, input field_t vay,
                            input field_t vbx, input field_t vby,
                            input field_t vcx, input field_t vcy);
    while (send_idle != 0 && $urandom_range(99) < send_idle) begin
      cmd_ch.valid <= 1'b0;
      @(negedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.cmd   <= c;
    cmd_ch.ax    <= vax;
    cmd_ch.ay    <= vay;
    cmd_ch.bx    <= vbx;
    cmd_ch.by    <= vby;
    cmd_ch.cx    <= vcx;
    cmd_ch.cy    <= vcy;
    do @(posedge clk); while (!cmd_ch.ready);
    beats_sent++;
    @(negedge clk);
  endtask

  // next beat; the unused vertex fields carry noise
  task automatic next_beat();
    drive_beat(CmdNext, rand_field(), rand_field(), rand_field(), rand_field(),
               rand_field(), rand_field());
  endtask

  // start a triangle, then ask for pixels until the cap or, if asked,
  // until an end marker comes back
  task automatic run_triangle(input field_t vax, input field_t vay, input field_t vbx,
                              input field_t vby, input field_t vcx, input field_t vcy,
                              input int max_nexts, input bit stop_at_end);
    int ends_before;
    int n;
    drive_beat(CmdStart, vax, vay, vbx, vby, vcx, vcy);
    ends_before = ends_seen;
    n = 0;
    while (n < max_nexts && !(stop_at_end && ends_seen != ends_before)) begin
      next_beat();
      n++;
    end
  endtask

  // hold off the sender until every pixel is back, let the block settle,
  // then write the color register
  task automatic set_color(input logic [ColorBits-1:0] c);
    cmd_ch.valid <= 1'b0;
    wait (pending == 0);
    repeat (SettlePause) @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= c;
    @(negedge clk);
    cfg_we <= 1'b0;
    color_writes++;
  endtask

  task automatic random_sequence();
    int     pick;
    int     span;
    field_t ox;
    field_t oy;
    pick = $urandom_range(99);
    if (pick < 4) begin
      // full-range vertices, one to three next beats, cut short without waiting for the end marker
      run_triangle(rand_field(), rand_field(), rand_field(), rand_field(),
                   rand_field(), rand_field(), $urandom_range(1, 3), 1'b0);
    end else if (pick < 9) begin
      // stray next: continues the current triangle or gets an end marker
      next_beat();
    end else begin
      // small triangle anywhere in the plane, mostly drawn to the end
      span = ($urandom_range(3) == 0) ? 12 : 4;
      ox   = field_t'($urandom_range(0, 16'hFFFF - span));
      oy   = field_t'($urandom_range(0, 16'hFFFF - span));
      run_triangle(ox + field_t'($urandom_range(0, span)), oy + field_t'($urandom_range(0, span)),
                   ox + field_t'($urandom_range(0, span)), oy + field_t'($urandom_range(0, span)),
                   ox + field_t'($urandom_range(0, span)), oy + field_t'($urandom_range(0, span)),
                   ($urandom_range(4) == 0) ? $urandom_range(1, 8) : 400, 1'b1);
    end
  endtask

  initial begin : stimulus
    int phase_goal;
    int last_color_at;
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_data     = '0;
    cmd_ch.valid = 1'b0;
    cmd_ch.cmd   = CmdStart;
    cmd_ch.ax    = '0;
    cmd_ch.ay    = '0;
    cmd_ch.bx    = '0;
    cmd_ch.by    = '0;
    cmd_ch.cx    = '0;
    cmd_ch.cy    = '0;
    send_idle    = 18;
    recv_idle    = 49;
    beats_sent   = 0;
    color_writes = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: next with nothing started gives end markers
    next_beat();
    next_beat();
    set_color(24'hFFFFFF);
    // extreme corners, vertical first edge: the left column holds only its vertex;
    // cut short, so the following start drops it
    run_triangle(16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 3, 1'b0);
    // all ones, degenerate point: vertex, end marker, then more markers while done
    run_triangle(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 3, 1'b0);
    // reversed x order and a column fill that ends at the top coordinate
    run_triangle(16'd102, 16'hFFFF, 16'd101, 16'hFFFF, 16'd100, 16'hFFFE, 6, 1'b0);
    // b and c share a column: the long edge runs out before the last fill
    run_triangle(16'd10, 16'd20, 16'd12, 16'd21, 16'd12, 16'd24, 20, 1'b1);
    // all three x equal, ties in the sort
    run_triangle(16'h0007, 16'h0009, 16'h0007, 16'h0003, 16'h0007, 16'h0006, 4, 1'b1);
    // alternating bit patterns
    run_triangle(16'hAAAA, 16'h5555, 16'hAAAD, 16'h5552, 16'hAAAB, 16'h5558, 30, 1'b1);

    // random phases: sender/receiver idling 18/49, then 49/18, then none
    for (int ph = 0; ph < 3; ph++) begin
      send_idle     = (ph == 0) ? 18 : (ph == 1) ? 49 : 0;
      recv_idle     = (ph == 0) ? 49 : (ph == 1) ? 18 : 0;
      phase_goal    = beats_sent + RandomBeats / 3;
      last_color_at = beats_sent - ColorEvery;
      while (beats_sent < phase_goal) begin
        if (beats_sent - last_color_at >= ColorEvery) begin
          set_color((color_writes % 4 == 1) ? 24'h000000 :
                    (color_writes % 4 == 0) ? 24'hFFFFFF :
                    24'($urandom_range(0, 24'hFFFFFF)));
          last_color_at = beats_sent;
        end
        random_sequence();
      end
    end

    // drain: wait for every expected pixel, then idle for DrainPause clock edges
    cmd_ch.valid <= 1'b0;
    wait (pending == 0);
    repeat (DrainPause) @(posedge clk);
    $display("run: %0d command beats, %0d pixels and %0d end markers checked, %0d color writes",
             beats_sent, pixels_seen, ends_seen, color_writes);
    $display("run: sender/receiver idling 18/49, 49/18 and 0/0 percent, %0d mismatches",
             mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== triangle_column_fill_rasterizer.f =====
rtl/core/tcf_pkg.sv
rtl/core/tcf_if.sv
rtl/core/tcf_init.sv
rtl/core/tcf_step.sv
rtl/core/triangle_column_fill_rasterizer.sv
rtl/core/tcf_checker.sv
verif/tcf_result_checker.sv
verif/triangle_column_fill_rasterizer_test.sv
